>>> design/afrg_pkg.sv
// Shared types and codes for the authenticated frame replay gate.
package afrg_pkg;

    // Action codes carried in a request
    localparam logic [1:0] ACT_SUBMIT     = 2'd0;
    localparam logic [1:0] ACT_WIN_RESET  = 2'd1;
    localparam logic [1:0] ACT_STAT_RESET = 2'd2;

    // Verdict codes carried in a response
    localparam logic [2:0] VERDICT_ACCEPT  = 3'd0;
    localparam logic [2:0] VERDICT_SHORT   = 3'd1;
    localparam logic [2:0] VERDICT_BAD_TAG = 3'd2;
    localparam logic [2:0] VERDICT_REPLAY  = 3'd3;
    localparam logic [2:0] VERDICT_NOFRAME = 3'd4;

    // 4 counter bytes + 32 tag bytes of overhead, at least 1 body byte
    localparam logic [15:0] FRAME_OVERHEAD = 16'd36;
    localparam logic [15:0] MIN_FRAME_LEN  = 16'd37;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] frame_len;
        logic [31:0] frame_counter;
        logic        tag_ok;
    } t_req;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [15:0] body_bytes;
        logic [31:0] peak_counter;
        logic [31:0] accepted_count;
        logic [31:0] short_count;
        logic [31:0] bad_tag_count;
        logic [31:0] replay_count;
    } t_rsp;

endpackage

>>> design/auth_frame_replay_gate_top.sv
// Authenticated command frame gate: length, key, tag and sliding-window replay checks.
// Path: input register, then result register. Throughput: one request per cycle
//   absent output stall; a stalled result holds back the request in the input register.
// The window check is one compare, subtract and shift.
// Reset (synchronous, active low) clears the key flag, the replay window, the
//   statistics and both valid flags; no clearing pass is needed.
module auth_frame_replay_gate_top
    import afrg_pkg::*;
#(
    parameter int WINDOW_BITS = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_stall,
    input  t_req  i_req,
    output logic  o_rsp_valid,
    input  logic  i_rsp_stall,
    output t_rsp  o_rsp,
    input  logic  i_key_we,
    input  logic  i_key_wdata
);

    localparam int          DW    = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
    localparam logic [31:0] WIN_W = 32'(WINDOW_BITS);

    // Registers
    logic                   r_key;
    logic                   r_in_valid;
    t_req                   r_in;
    logic                   r_out_valid;
    t_rsp                   r_out;
    logic [31:0]            r_top;
    logic [WINDOW_BITS-1:0] r_bitmap;
    logic                   r_started;
    logic [31:0]            r_acc_cnt;
    logic [31:0]            r_short_cnt;
    logic [31:0]            r_bad_cnt;
    logic [31:0]            r_replay_cnt;

    // Next values
    logic [31:0]            n_top;
    logic [WINDOW_BITS-1:0] n_bitmap;
    logic                   n_started;
    logic [31:0]            n_acc_cnt;
    logic [31:0]            n_short_cnt;
    logic [31:0]            n_bad_cnt;
    logic [31:0]            n_replay_cnt;
    t_rsp                   n_out;

    logic                   w_adv;
    logic                   w_load;
    logic [31:0]            w_fwd_dist;
    logic [31:0]            w_back_dist;
    logic                   w_admit;

    // Pipeline control: the stage moves when the result register is empty or not stalled
    assign w_adv       = r_in_valid && (!r_out_valid || !i_rsp_stall);
    assign o_req_stall = r_in_valid && !w_adv;
    assign w_load      = i_req_valid && !o_req_stall;

    // Key register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= 1'b0;
        end else if (i_key_we) begin
            r_key <= i_key_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_load) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in <= i_req;
        end
    end

    // Distances from the current top of window
    assign w_fwd_dist  = r_in.frame_counter - r_top;
    assign w_back_dist = r_top - r_in.frame_counter;

    // Check chain and state update for the request in the input register
    always_comb begin
        n_top        = r_top;
        n_bitmap     = r_bitmap;
        n_started    = r_started;
        n_acc_cnt    = r_acc_cnt;
        n_short_cnt  = r_short_cnt;
        n_bad_cnt    = r_bad_cnt;
        n_replay_cnt = r_replay_cnt;
        w_admit      = 1'b0;
        n_out.verdict    = VERDICT_NOFRAME;
        n_out.body_bytes = '0;

        case (r_in.action)
            ACT_SUBMIT: begin
                if (r_in.frame_len < MIN_FRAME_LEN) begin
                    n_out.verdict = VERDICT_SHORT;
                    n_short_cnt   = r_short_cnt + 32'd1;
                end else if (!r_key || !r_in.tag_ok) begin
                    n_out.verdict = VERDICT_BAD_TAG;
                    n_bad_cnt     = r_bad_cnt + 32'd1;
                end else begin
                    // Sliding-window replay filter
                    if (r_in.frame_counter == 32'd0) begin
                        w_admit = 1'b0;
                    end else if (!r_started) begin
                        // First frame after a window reset seeds the window
                        w_admit   = 1'b1;
                        n_top     = r_in.frame_counter;
                        n_bitmap  = WINDOW_BITS'(1);
                        n_started = 1'b1;
                    end else if (r_in.frame_counter > r_top) begin
                        w_admit = 1'b1;
                        n_top   = r_in.frame_counter;
                        if (w_fwd_dist >= WIN_W) begin
                            n_bitmap = WINDOW_BITS'(1);
                        end else begin
                            n_bitmap = (r_bitmap << w_fwd_dist[DW-1:0])
                                       | WINDOW_BITS'(1);
                        end
                    end else if (w_back_dist >= WIN_W) begin
                        w_admit = 1'b0;
                    end else if (r_bitmap[w_back_dist[DW-1:0]]) begin
                        w_admit = 1'b0;
                    end else begin
                        w_admit  = 1'b1;
                        n_bitmap = r_bitmap;
                        n_bitmap[w_back_dist[DW-1:0]] = 1'b1;
                    end

                    if (w_admit) begin
                        n_out.verdict    = VERDICT_ACCEPT;
                        n_out.body_bytes = r_in.frame_len - FRAME_OVERHEAD;
                        n_acc_cnt        = r_acc_cnt + 32'd1;
                    end else begin
                        n_out.verdict = VERDICT_REPLAY;
                        n_replay_cnt  = r_replay_cnt + 32'd1;
                    end
                end
            end
            ACT_WIN_RESET: begin
                n_top     = '0;
                n_bitmap  = '0;
                n_started = 1'b0;
            end
            ACT_STAT_RESET: begin
                n_acc_cnt    = '0;
                n_short_cnt  = '0;
                n_bad_cnt    = '0;
                n_replay_cnt = '0;
            end
            default: begin
                // Unused action code: no change
            end
        endcase

        n_out.peak_counter   = n_top;
        n_out.accepted_count = n_acc_cnt;
        n_out.short_count    = n_short_cnt;
        n_out.bad_tag_count  = n_bad_cnt;
        n_out.replay_count   = n_replay_cnt;
    end

    // Window and statistics state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top        <= '0;
            r_bitmap     <= '0;
            r_started    <= 1'b0;
            r_acc_cnt    <= '0;
            r_short_cnt  <= '0;
            r_bad_cnt    <= '0;
            r_replay_cnt <= '0;
        end else if (w_adv) begin
            r_top        <= n_top;
            r_bitmap     <= n_bitmap;
            r_started    <= n_started;
            r_acc_cnt    <= n_acc_cnt;
            r_short_cnt  <= n_short_cnt;
            r_bad_cnt    <= n_bad_cnt;
            r_replay_cnt <= n_replay_cnt;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // Checks

    // Reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !o_rsp_valid)
        else $error("pipeline not empty after reset");

    // A seeded window always has its top counter marked
    a_top_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> r_bitmap[0] && r_top != 32'd0)
        else $error("seeded window lost its top mark");

    // An unseeded window holds no marks and no top
    a_idle_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> r_bitmap == '0 && r_top == 32'd0)
        else $error("unseeded window holds state");

    // An accepted frame always carries a body
    a_accept_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.verdict == VERDICT_ACCEPT |-> o_rsp.body_bytes != 16'd0)
        else $error("accepted frame with empty body");

    // Only a request in the input stage can be held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_stall |-> r_in_valid && o_rsp_valid && i_rsp_stall)
        else $error("request stall without a blocked result");

endmodule

>>> test/afrg_verdict_checker.sv
// Verdict checker for the frame replay gate: predicts each response and compares it.
module afrg_verdict_checker
    import afrg_pkg::*;
#(
    parameter int WINDOW_BITS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_stall,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_stall,
    input  t_rsp i_rsp,
    input  logic i_key_we,
    input  logic i_key_wdata,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_rsp_checked,
    output int   o_accepts_seen,
    output int   o_replays_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] WIN_MASK = {64{1'b1}} >> (64 - WINDOW_BITS);
    localparam int REPORT_MAX = 10;

    // Shadow copy of the gate's key flag, replay window and statistics
    logic        key_on;
    logic [31:0] top_ctr;
    logic [63:0] seen_map;
    logic        win_open;
    logic [31:0] n_accept;
    logic [31:0] n_short;
    logic [31:0] n_bad_tag;
    logic [31:0] n_replay;

    // Predicted responses, oldest first
    t_rsp verdicts_due[$];

    // Judge one request against the shadow state and update it
    function automatic t_rsp judge_frame(input t_req r);
        t_rsp        res;
        logic        admit;
        logic [31:0] gap;
        res = '0;
        res.verdict = VERDICT_NOFRAME;
        admit = 1'b0;
        gap = '0;
        case (r.action)
            ACT_SUBMIT: begin
                if (r.frame_len < MIN_FRAME_LEN) begin
                    res.verdict = VERDICT_SHORT;
                    n_short = n_short + 32'd1;
                end else if (!key_on || !r.tag_ok) begin
                    res.verdict = VERDICT_BAD_TAG;
                    n_bad_tag = n_bad_tag + 32'd1;
                end else begin
                    // sliding window: counter zero never passes
                    if (r.frame_counter == '0) begin
                        admit = 1'b0;
                    end else if (!win_open) begin
                        top_ctr = r.frame_counter;
                        seen_map = 64'd1;
                        win_open = 1'b1;
                        admit = 1'b1;
                    end else if (r.frame_counter > top_ctr) begin
                        gap = r.frame_counter - top_ctr;
                        if (gap >= WINDOW_BITS)
                            seen_map = 64'd1;
                        else
                            seen_map = ((seen_map << gap) | 64'd1) & WIN_MASK;
                        top_ctr = r.frame_counter;
                        admit = 1'b1;
                    end else begin
                        gap = top_ctr - r.frame_counter;
                        if (gap >= WINDOW_BITS || seen_map[gap]) begin
                            admit = 1'b0;
                        end else begin
                            seen_map[gap] = 1'b1;
                            admit = 1'b1;
                        end
                    end
                    if (admit) begin
                        res.verdict = VERDICT_ACCEPT;
                        res.body_bytes = r.frame_len - FRAME_OVERHEAD;
                        n_accept = n_accept + 32'd1;
                    end else begin
                        res.verdict = VERDICT_REPLAY;
                        n_replay = n_replay + 32'd1;
                    end
                end
            end
            ACT_WIN_RESET: begin
                top_ctr = '0;
                seen_map = '0;
                win_open = 1'b0;
            end
            ACT_STAT_RESET: begin
                n_accept = '0;
                n_short = '0;
                n_bad_tag = '0;
                n_replay = '0;
            end
            default: ;
        endcase
        res.peak_counter = top_ctr;
        res.accepted_count = n_accept;
        res.short_count = n_short;
        res.bad_tag_count = n_bad_tag;
        res.replay_count = n_replay;
        return res;
    endfunction

    // Watch both channels and the key port at each rising edge
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            key_on = 1'b0;
            top_ctr = '0;
            seen_map = '0;
            win_open = 1'b0;
            n_accept = '0;
            n_short = '0;
            n_bad_tag = '0;
            n_replay = '0;
            verdicts_due.delete();
        end else begin
            // response side: compare with the oldest prediction
            if (i_rsp_valid && !i_rsp_stall) begin
                o_rsp_checked++;
                if (i_rsp.verdict == VERDICT_ACCEPT) o_accepts_seen++;
                if (i_rsp.verdict == VERDICT_REPLAY) o_replays_seen++;
                if (verdicts_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX)
                        $display("unexpected response at %0t: verdict %0d top %h",
                                 $realtime, i_rsp.verdict, i_rsp.peak_counter);
                end else begin
                    want = verdicts_due.pop_front();
                    if (i_rsp.verdict !== want.verdict
                            || i_rsp.body_bytes !== want.body_bytes
                            || i_rsp.peak_counter !== want.peak_counter
                            || i_rsp.accepted_count !== want.accepted_count
                            || i_rsp.short_count !== want.short_count
                            || i_rsp.bad_tag_count !== want.bad_tag_count
                            || i_rsp.replay_count !== want.replay_count) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX) begin
                            $display("mismatch on response %0d at %0t", o_rsp_checked,
                                     $realtime);
                            $display("  want v%0d len %0d top %h acc %0d sh %0d bad %0d rep %0d",
                                     want.verdict, want.body_bytes, want.peak_counter,
                                     want.accepted_count, want.short_count,
                                     want.bad_tag_count, want.replay_count);
                            $display("  got  v%0d len %0d top %h acc %0d sh %0d bad %0d rep %0d",
                                     i_rsp.verdict, i_rsp.body_bytes, i_rsp.peak_counter,
                                     i_rsp.accepted_count, i_rsp.short_count,
                                     i_rsp.bad_tag_count, i_rsp.replay_count);
                        end
                    end
                end
            end
            // request side: predict its response
            if (i_req_valid && !i_req_stall)
                verdicts_due.push_back(judge_frame(i_req));
            if (i_key_we)
                key_on = i_key_wdata;
        end
        o_pending = verdicts_due.size();
    end

endmodule

>>> test/tb.sv
// Top of the frame replay gate testbench: clock, reset, request stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import afrg_pkg::*;

    localparam int WIN_BITS     = 64;
    localparam int PCT_IDLE     = 29;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 120;
    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int TAIL_CYCLES  = 8;
    localparam logic [1:0] ACT_UNDEFINED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    t_req req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    t_rsp rsp;
    logic key_we = 1'b0;
    logic key_wdata = 1'b0;

    int fail_count;
    int pending;
    int rsp_checked;
    int accepts_seen;
    int replays_seen;

    int reqs_sent = 0;
    int key_writes = 0;
    int hold_left = 0;
    logic held = 1'b0;
    logic steady = 1'b0;
    logic [31:0] ctr_base = 32'd1000;

    auth_frame_replay_gate_top #(
        .WINDOW_BITS(WIN_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .o_req_stall(req_stall),
        .i_req      (req),
        .o_rsp_valid(rsp_valid),
        .i_rsp_stall(rsp_stall),
        .o_rsp      (rsp),
        .i_key_we   (key_we),
        .i_key_wdata(key_wdata)
    );

    afrg_verdict_checker #(
        .WINDOW_BITS(WIN_BITS)
    ) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_stall   (req_stall),
        .i_req         (req),
        .i_rsp_valid   (rsp_valid),
        .i_rsp_stall   (rsp_stall),
        .i_rsp         (rsp),
        .i_key_we      (key_we),
        .i_key_wdata   (key_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_rsp_checked (rsp_checked),
        .o_accepts_seen(accepts_seen),
        .o_replays_seen(replays_seen)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, one long hold-off once traffic is flowing
    initial begin
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp_stall <= 1'b1;
            end else if (!held && reqs_sent >= HOLD_AT) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_stall <= 1'b1;
            end else begin
                rsp_stall <= !steady && ($urandom_range(99) < PCT_IDLE);
            end
        end
    end

    // Watchdog: too many cycles with no request or response moving
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic t_req frame(input logic [1:0] act, input logic [15:0] len,
                                   input logic [31:0] ctr, input logic tag);
        t_req r;
        r.action = act;
        r.frame_len = len;
        r.frame_counter = ctr;
        r.tag_ok = tag;
        return r;
    endfunction

    // Random request: mostly frames with counters near a moving base
    function automatic t_req draw_request();
        t_req r;
        int   pick;
        r.tag_ok = ($urandom_range(99) < 90);
        pick = $urandom_range(99);
        if (pick < 2)
            r.action = ACT_WIN_RESET;
        else if (pick < 4)
            r.action = ACT_STAT_RESET;
        else if (pick < 5)
            r.action = ACT_UNDEFINED;
        else
            r.action = ACT_SUBMIT;
        pick = $urandom_range(99);
        if (pick < 6)
            r.frame_len = 16'($urandom_range(0, 36));
        else if (pick < 8)
            r.frame_len = 16'($urandom);
        else if (pick < 10)
            r.frame_len = 16'hFFFF;
        else if (pick < 12)
            r.frame_len = MIN_FRAME_LEN;
        else
            r.frame_len = 16'($urandom_range(37, 1536));
        pick = $urandom_range(99);
        if (pick < 3)
            r.frame_counter = '0;
        else if (pick < 5)
            r.frame_counter = $urandom;
        else if (pick < 12)
            r.frame_counter = ctr_base + 32'($urandom_range(40, 4000));
        else
            r.frame_counter = ctr_base - 32'd70 + 32'($urandom_range(0, 80));
        // far counters pull the base along so later ones land near the window
        if (pick >= 3 && pick < 12 && r.frame_counter > ctr_base)
            ctr_base = r.frame_counter;
        ctr_base = ctr_base + 32'($urandom_range(0, 2));
        return r;
    endfunction

    // Offer one request, starting and ending at a falling edge
    task automatic offer(input t_req r);
        while (!steady && $urandom_range(99) < PCT_IDLE) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        reqs_sent++;
        @(negedge clk);
    endtask

    // Drain all outstanding responses, then write the key flag
    task automatic set_key(input logic v);
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        key_we <= 1'b1;
        key_wdata <= v;
        @(negedge clk);
        key_we <= 1'b0;
        key_writes++;
    endtask

    initial begin
        logic key_sel;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no key loaded: length check first, then everything is a bad tag
        offer(frame(ACT_SUBMIT, MIN_FRAME_LEN, 32'd5, 1'b1));
        offer(frame(ACT_SUBMIT, 16'd36, 32'd5, 1'b1));
        offer(frame(ACT_SUBMIT, 16'd0, 32'hFFFF_FFFF, 1'b0));
        offer(frame(ACT_SUBMIT, 16'hFFFF, 32'd7, 1'b0));
        set_key(1'b1);

        // counter zero before seeding, seeding, duplicates, window edges, a bad tag and a short frame
        offer(frame(ACT_SUBMIT, MIN_FRAME_LEN, 32'd0, 1'b1));
        offer(frame(ACT_SUBMIT, 16'hFFFF, 32'd100, 1'b1));
        offer(frame(ACT_SUBMIT, MIN_FRAME_LEN, 32'd100, 1'b1));
        offer(frame(ACT_SUBMIT, 16'd40, 32'd99, 1'b1));
        offer(frame(ACT_SUBMIT, 16'd40, 32'd37, 1'b1));
        offer(frame(ACT_SUBMIT, 16'd40, 32'd36, 1'b1));
        offer(frame(ACT_SUBMIT, 16'd40, 32'd163, 1'b1));
        offer(frame(ACT_SUBMIT, 16'd40, 32'd227, 1'b1));
        offer(frame(ACT_SUBMIT, 16'd40, 32'd164, 1'b1));
        offer(frame(ACT_SUBMIT, 16'd40, 32'd300, 1'b0));
        offer(frame(ACT_SUBMIT, 16'd36, 32'd301, 1'b1));
        // action codes, including the unused one
        offer(frame(ACT_UNDEFINED, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        offer(frame(ACT_STAT_RESET, 16'd0, 32'd0, 1'b0));
        offer(frame(ACT_WIN_RESET, 16'd0, 32'd0, 1'b0));
        // reseed at the top of the counter range, a stale low counter, then a reset and reseed at 1
        offer(frame(ACT_SUBMIT, MIN_FRAME_LEN, 32'hFFFF_FFFF, 1'b1));
        offer(frame(ACT_SUBMIT, MIN_FRAME_LEN, 32'hFFFF_FFFE, 1'b1));
        offer(frame(ACT_SUBMIT, MIN_FRAME_LEN, 32'd1, 1'b1));
        offer(frame(ACT_WIN_RESET, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        offer(frame(ACT_SUBMIT, MIN_FRAME_LEN, 32'd1, 1'b1));

        // random phases, key written before each (off in phase 5), window reset after each write
        for (int p = 0; p < PHASES; p++) begin
            key_sel = (p != 5);
            set_key(key_sel);
            if (p == 2) ctr_base = $urandom | 32'h100;
            if (p == 6) ctr_base = 32'hFFFF_F000;
            steady = (p == 3);
            offer(frame(ACT_WIN_RESET, 16'd0, 32'd0, 1'b0));
            repeat (PHASE_ITEMS) offer(draw_request());
        end
        steady = 1'b0;

        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("summary: %0d requests over %0d key writes, one %0d-cycle output hold",
                 reqs_sent, key_writes, HOLD_CYCLES);
        $display("summary: %0d responses checked, %0d accepted, %0d replay rejects",
                 rsp_checked, accepts_seen, replays_seen);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
design/afrg_pkg.sv
design/auth_frame_replay_gate_top.sv
test/afrg_verdict_checker.sv
test/tb.sv
